// ----- rtl/m3ma_pkg.sv -----
// shared types, widths and the three-way median for the median/average filter
package m3ma_pkg;

  localparam int unsigned DATA_W = 16;

  typedef logic signed [DATA_W-1:0] data_t;

  function automatic data_t median3(data_t a, data_t b, data_t c);
    data_t lo;
    data_t hi;
    data_t res;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    priority if (c <= lo) begin
      res = lo;
    end else if (c >= hi) begin
      res = hi;
    end else begin
      res = c;
    end
    return res;
  endfunction

endpackage

// ----- rtl/m3ma_cell.sv -----
// one window cell: holds a sample and passes it to its neighbor on shift
module m3ma_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            shift_i,
  input  m3ma_pkg::data_t d_i,
  output m3ma_pkg::data_t q_o
);

  m3ma_pkg::data_t data_q;
  m3ma_pkg::data_t data_d;

  assign data_d = shift_i ? d_i : data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= '0;
    end else begin
      data_q <= data_d;
    end
  end

  assign q_o = data_q;

endmodule

// ----- rtl/m3ma_div.sv -----
// signed divide by a constant via reciprocal multiply, truncating toward zero
module m3ma_div #(
  parameter int unsigned DIVISOR = 10,
  parameter int unsigned SUM_W   = 20
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [SUM_W-1:0] sum_i,
  output m3ma_pkg::data_t         quot_o
);

  localparam int unsigned SHIFT  = SUM_W + $clog2(DIVISOR);
  localparam int unsigned PROD_W = 2 * SUM_W + 1;
  localparam longint unsigned MULT_L = ((64'd1 << SHIFT) + DIVISOR - 1) / DIVISOR;
  localparam logic [SUM_W:0] MULT = MULT_L[SUM_W:0];

  logic [SUM_W-1:0]  mag;
  logic [PROD_W-1:0] prod_d;
  logic [PROD_W-1:0] prod_q;
  logic              neg_q;
  m3ma_pkg::data_t   quot;

  assign mag    = sum_i[SUM_W-1] ? SUM_W'(-sum_i) : SUM_W'(sum_i);
  assign prod_d = PROD_W'(mag) * PROD_W'(MULT);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      neg_q  <= sum_i[SUM_W-1];
    end
  end

  assign quot   = prod_q[SHIFT +: m3ma_pkg::DATA_W];
  assign quot_o = neg_q ? -quot : quot;

endmodule

// ----- rtl/median3_moving_average_filter.sv -----
// top level: offset correction, median-of-three and moving average filter
// Each accepted raw word has the gyro offset subtracted (wrapping to 16 bits),
// enters a three-cell median window, and the window median enters an
// AVG_DEPTH-cell average window kept with a running sum. One request is taken
// every clock unless the output stalls; a result passes in turn through the
// median window, running sum, reciprocal-multiply and output registers; output
// stalls freeze the whole pipeline. Both windows and offset reset to zero.
// The user must write the offset only while the filter is idle (not enforced).
module median3_moving_average_filter #(
  parameter int unsigned AVG_DEPTH = 10
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            gyro_offset_we_i,
  input  logic [15:0]     gyro_offset_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [15:0]     raw_rate_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output m3ma_pkg::data_t median_value_o,
  output m3ma_pkg::data_t filtered_rate_o
);

  localparam int unsigned MED_DEPTH = 3;
  localparam int unsigned SUM_W     = m3ma_pkg::DATA_W + $clog2(AVG_DEPTH);

  logic [15:0] offset_q;
  logic        en;
  logic        in_acc;
  logic        v1_q, v2_q, v3_q, out_valid_q;
  logic        avg_shift;

  m3ma_pkg::data_t med_d [MED_DEPTH];
  m3ma_pkg::data_t med_q [MED_DEPTH];
  m3ma_pkg::data_t avg_d [AVG_DEPTH];
  m3ma_pkg::data_t avg_q [AVG_DEPTH];
  m3ma_pkg::data_t median;
  m3ma_pkg::data_t med1_q, med2_q;
  m3ma_pkg::data_t quot;
  m3ma_pkg::data_t med_out_q, filt_out_q;

  logic signed [SUM_W-1:0] sum_d, sum_q;

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;
  assign in_acc     = in_valid_i && en;
  assign avg_shift  = v1_q && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
    end else if (gyro_offset_we_i) begin
      offset_q <= gyro_offset_i;
    end
  end

  // median window chain
  assign med_d[0] = m3ma_pkg::data_t'(raw_rate_i - offset_q);

  for (genvar i = 0; i < MED_DEPTH; i++) begin : g_med
    if (i > 0) begin : g_link
      assign med_d[i] = med_q[i-1];
    end
    m3ma_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (in_acc),
      .d_i     (med_d[i]),
      .q_o     (med_q[i])
    );
  end

  assign median = m3ma_pkg::median3(med_q[0], med_q[1], med_q[2]);

  // average window chain
  assign avg_d[0] = median;

  for (genvar i = 0; i < AVG_DEPTH; i++) begin : g_avg
    if (i > 0) begin : g_link
      assign avg_d[i] = avg_q[i-1];
    end
    m3ma_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (avg_shift),
      .d_i     (avg_d[i]),
      .q_o     (avg_q[i])
    );
  end

  assign sum_d = sum_q + SUM_W'(median) - SUM_W'(avg_q[AVG_DEPTH-1]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (avg_shift) begin
      sum_q <= sum_d;
    end
  end

  m3ma_div #(
    .DIVISOR (AVG_DEPTH),
    .SUM_W   (SUM_W)
  ) u_div (
    .clk_i  (clk_i),
    .en_i   (en),
    .sum_i  (sum_q),
    .quot_o (quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q        <= in_valid_i;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      out_valid_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      med1_q     <= median;
      med2_q     <= med1_q;
      med_out_q  <= med2_q;
      filt_out_q <= quot;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign median_value_o  = med_out_q;
  assign filtered_rate_o = filt_out_q;

endmodule

// ----- tb/sv/median3_moving_average_filter_tb.sv -----
// testbench for the median-of-three and moving average gyro rate filter
`timescale 1ns / 1ps

module median3_moving_average_filter_tb;

  localparam int unsigned AVG_DEPTH      = 10;
  localparam int unsigned MED_DEPTH      = 3;
  localparam int unsigned HOLD_CYCLES    = 90;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES   = 12;
  localparam int unsigned PHASE_ITEMS    = 255;

  typedef struct packed {
    m3ma_pkg::data_t median;
    m3ma_pkg::data_t mean;
  } filter_result_t;

  logic            clk_i;
  logic            rst_ni;
  logic            gyro_offset_we_i;
  logic [15:0]     gyro_offset_i;
  logic            in_valid_i;
  logic            in_ready_o;
  logic [15:0]     raw_rate_i;
  logic            out_valid_o;
  logic            out_ready_i;
  m3ma_pkg::data_t median_value_o;
  m3ma_pkg::data_t filtered_rate_o;

  filter_result_t  filter_results_q[$];
  m3ma_pkg::data_t corr_window[MED_DEPTH];
  m3ma_pkg::data_t median_history[AVG_DEPTH];
  logic [15:0]     offset_shadow;
  logic [15:0]     last_raw;

  int unsigned err_cnt;
  int unsigned burst_left;
  int unsigned idle_cycles;
  int unsigned hold_left;
  int unsigned stall_mode;
  int unsigned stall_age;
  logic        steady_send;
  logic        hold_req;

  median3_moving_average_filter #(
    .AVG_DEPTH(AVG_DEPTH)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .gyro_offset_we_i(gyro_offset_we_i),
    .gyro_offset_i   (gyro_offset_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .raw_rate_i      (raw_rate_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .median_value_o  (median_value_o),
    .filtered_rate_o (filtered_rate_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic m3ma_pkg::data_t middle_of(m3ma_pkg::data_t a,
                                                m3ma_pkg::data_t b,
                                                m3ma_pkg::data_t c);
    m3ma_pkg::data_t res;
    if ((a >= b && a <= c) || (a <= b && a >= c)) begin
      res = a;
    end else if ((b >= a && b <= c) || (b <= a && b >= c)) begin
      res = b;
    end else begin
      res = c;
    end
    return res;
  endfunction

  function automatic void clear_filter_state();
    offset_shadow = '0;
    for (int i = 0; i < MED_DEPTH; i++) corr_window[i] = '0;
    for (int i = 0; i < AVG_DEPTH; i++) median_history[i] = '0;
  endfunction

  function automatic void predict_filter_output(logic [15:0] raw);
    logic [15:0]    diff;
    int             sum;
    filter_result_t res;
    diff = raw - offset_shadow;
    for (int i = MED_DEPTH - 1; i > 0; i--) corr_window[i] = corr_window[i-1];
    corr_window[0] = m3ma_pkg::data_t'(diff);
    res.median = middle_of(corr_window[0], corr_window[1], corr_window[2]);
    for (int i = AVG_DEPTH - 1; i > 0; i--) median_history[i] = median_history[i-1];
    median_history[0] = res.median;
    sum = 0;
    for (int i = 0; i < AVG_DEPTH; i++) sum += int'(median_history[i]);
    res.mean = m3ma_pkg::data_t'(sum / int'(AVG_DEPTH));
    filter_results_q.push_back(res);
  endfunction

  // one request; valid stays up inside a burst
  task automatic send_raw(input logic [15:0] raw);
    int unsigned gap;
    in_valid_i <= 1'b1;
    raw_rate_i <= raw;
    do @(posedge clk_i); while (!in_ready_o);
    predict_filter_output(raw);
    last_raw = raw;
    if (!steady_send) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(0, 24);
        gap = $urandom_range(1, 10);
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (filter_results_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_offset(input logic [15:0] value);
    gyro_offset_we_i <= 1'b1;
    gyro_offset_i    <= value;
    @(posedge clk_i);
    gyro_offset_we_i <= 1'b0;
    offset_shadow = value;
    @(posedge clk_i);
  endtask

  function automatic logic [15:0] next_raw();
    logic [15:0] raw;
    case ($urandom_range(0, 9))
      0, 1: raw = 16'($urandom);
      2, 3, 4: raw = last_raw + 16'($urandom_range(0, 64)) - 16'd32;
      5: raw = offset_shadow + 16'($urandom_range(0, 400)) - 16'd200;
      6: begin
        case ($urandom_range(0, 3))
          0: raw = 16'h0000;
          1: raw = 16'hFFFF;
          2: raw = 16'h8000;
          default: raw = 16'h7FFF;
        endcase
      end
      7: raw = last_raw;
      8: raw = offset_shadow + 16'h8000 + 16'($urandom_range(0, 8)) - 16'd4;
      default: raw = last_raw + 16'($urandom_range(0, 8192)) - 16'd4096;
    endcase
    return raw;
  endfunction

  // zeroed windows, field extremes and ties with the reset offset
  task automatic test_startup_extremes();
    logic [15:0] seq[12];
    seq = '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'hFFFF,
            16'h0001, 16'h0000, 16'h0005, 16'h0005, 16'h0009, 16'h0005};
    foreach (seq[i]) send_raw(seq[i]);
    wait_idle();
  endtask

  // subtraction wraps with no saturation
  task automatic test_offset_wrap();
    write_offset(16'h8000);
    send_raw(16'h7FFF);
    send_raw(16'h0000);
    send_raw(16'hFFFF);
    wait_idle();
    write_offset(16'h7FFF);
    send_raw(16'h8000);
    send_raw(16'h0000);
    send_raw(16'hFFFF);
    wait_idle();
    write_offset(16'hFFFF);
    send_raw(16'hFFFF);
    send_raw(16'h7FFF);
    wait_idle();
  endtask

  task automatic test_random_offsets();
    logic [15:0] offsets[7];
    offsets = '{16'h7FFF, 16'h8000, 16'($urandom), 16'h0000,
                16'($urandom), 16'h0001, 16'($urandom)};
    foreach (offsets[p]) begin
      write_offset(offsets[p]);
      last_raw = offsets[p];
      steady_send = (p == 3);
      repeat (PHASE_ITEMS) send_raw(next_raw());
      steady_send = 1'b0;
      wait_idle();
    end
  endtask

  // output held off long enough for the input to back up
  task automatic test_backpressure();
    hold_req <= 1'b1;
    steady_send = 1'b1;
    repeat (60) send_raw(next_raw());
    steady_send = 1'b0;
    wait_idle();
  endtask

  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (hold_req) begin
      hold_req    <= 1'b0;
      hold_left    = HOLD_CYCLES - 1;
      out_ready_i <= 1'b0;
    end else begin
      if (stall_age == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_age  = $urandom_range(50, 300);
      end else begin
        stall_age--;
      end
      case (stall_mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= ($urandom_range(0, 3) != 0);
        2: out_ready_i <= ($urandom_range(0, 3) == 0);
        default: out_ready_i <= (stall_age % 7) > 2;
      endcase
    end
  end

  always @(posedge clk_i) begin
    filter_result_t exp_res;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (filter_results_q.size() == 0) begin
        $error("unexpected result: median_value %0d filtered_rate %0d",
               median_value_o, filtered_rate_o);
        err_cnt++;
      end else begin
        exp_res = filter_results_q.pop_front();
        if (median_value_o !== exp_res.median) begin
          $error("median_value: expected %0d, actual %0d", exp_res.median, median_value_o);
          err_cnt++;
        end
        if (filtered_rate_o !== exp_res.mean) begin
          $error("filtered_rate: expected %0d, actual %0d", exp_res.mean, filtered_rate_o);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst_ni           <= 1'b0;
    gyro_offset_we_i <= 1'b0;
    gyro_offset_i    <= '0;
    in_valid_i       <= 1'b0;
    raw_rate_i       <= '0;
    out_ready_i      <= 1'b0;
    hold_req         <= 1'b0;
    err_cnt     = 0;
    burst_left  = 0;
    idle_cycles = 0;
    hold_left   = 0;
    stall_mode  = 0;
    stall_age   = 0;
    steady_send = 1'b0;
    last_raw    = '0;
    clear_filter_state();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_startup_extremes();
    test_offset_wrap();
    test_random_offsets();
    test_backpressure();

    while (filter_results_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
